// ===== src/sfcd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfcd_pkg
// Shared constants and types for the serial frame CRC deframer.
// ----------------------------------------------------------------------------
package sfcd_pkg;

  localparam logic [7:0]  START_BYTE = 8'hA6;
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] CRC_INIT   = 16'h0000;
  localparam logic [7:0]  MIN_LEN    = 8'd4;
  localparam logic [7:0]  MAX_FRAME_RESET = 8'd80;

  typedef enum logic [1:0] {
    ST_INSIDE   = 2'd0,
    ST_CRC_GOOD = 2'd1,
    ST_CRC_BAD  = 2'd2,
    ST_ABORT    = 2'd3
  } frame_status_t;

  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_TYPE = 4'b0010,
    PH_LEN  = 4'b0100,
    PH_BODY = 4'b1000
  } phase_t;

endpackage

// ===== src/serial_frame_crc_deframer.sv =====
// ----------------------------------------------------------------------------
// serial_frame_crc_deframer
// Hunts for start byte 0xA6, checks the length byte against a configured
// limit, passes frame bytes on with their index and checks the CRC-16 tail.
// ----------------------------------------------------------------------------
// The result of an input transaction is in the output register next cycle.
// Throughput: one byte per cycle when not stalled; byte-wide CRC and frame
//   state updates fit between the input handshake and the output register.
// Reset: synchronous, active low; hunting state, limit 80, output empty.
module serial_frame_crc_deframer
  import sfcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,       // max_frame_bytes
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,       // [7:0] rx_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,      // [7:0] data_byte, [15:8] byte_index
  output logic [2:0]  out_tuser       // [1:0] frame_status, [2] frame_busy
);

  phase_t        phase_r, phase_nxt;
  logic [7:0]    position_r, position_nxt;
  logic [7:0]    frame_length_r, frame_length_nxt;
  logic [15:0]   crc_r, crc_nxt;
  logic [7:0]    crc_high_r, crc_high_nxt;
  logic [7:0]    max_frame_r;

  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic [7:0]    out_index_r, out_index_nxt;
  frame_status_t out_status_r, out_status_nxt;
  logic          out_busy_r, out_busy_nxt;

  logic          in_fire;
  logic          emit;
  logic [15:0]   crc_src;
  logic [15:0]   crc_upd;
  logic [8:0]    pos_plus2;
  logic [8:0]    pos_plus1;
  logic [8:0]    len_ext;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign crc_src = (phase_r == PH_HUNT) ? CRC_INIT : crc_r;

  sfcd_crc16 u_crc (
    .crc_in  (crc_src),
    .data_in (in_tdata),
    .crc_out (crc_upd)
  );

  assign pos_plus2 = {1'b0, position_r} + 9'd2;
  assign pos_plus1 = {1'b0, position_r} + 9'd1;
  assign len_ext   = {1'b0, frame_length_r};

  always_comb begin
    phase_nxt        = phase_r;
    position_nxt     = position_r;
    frame_length_nxt = frame_length_r;
    crc_nxt          = crc_r;
    crc_high_nxt     = crc_high_r;
    emit             = 1'b0;
    out_byte_nxt     = in_tdata;
    out_index_nxt    = position_r;
    out_status_nxt   = ST_INSIDE;
    out_busy_nxt     = 1'b1;

    case (phase_r)
      PH_HUNT: begin
        if (in_tdata == START_BYTE) begin
          emit             = 1'b1;
          crc_nxt          = crc_upd;
          crc_high_nxt     = 8'd0;
          frame_length_nxt = 8'd0;
          position_nxt     = 8'd1;
          phase_nxt        = PH_TYPE;
          out_index_nxt    = 8'd0;
        end
      end
      PH_TYPE: begin
        emit          = 1'b1;
        crc_nxt       = crc_upd;
        position_nxt  = 8'd2;
        phase_nxt     = PH_LEN;
        out_index_nxt = 8'd1;
      end
      PH_LEN: begin
        emit          = 1'b1;
        out_index_nxt = 8'd2;
        if (in_tdata < MIN_LEN || in_tdata >= max_frame_r) begin
          // drop the frame and go back to hunting
          phase_nxt      = PH_HUNT;
          position_nxt   = 8'd0;
          out_status_nxt = ST_ABORT;
          out_busy_nxt   = 1'b0;
        end else begin
          frame_length_nxt = in_tdata;
          // minimum length: the length byte doubles as the CRC high byte
          if (in_tdata == MIN_LEN) begin
            crc_high_nxt = in_tdata;
          end else begin
            crc_nxt = crc_upd;
          end
          position_nxt = 8'd3;
          phase_nxt    = PH_BODY;
        end
      end
      PH_BODY: begin
        emit = 1'b1;
        if (pos_plus2 < len_ext) begin
          crc_nxt = crc_upd;
        end else if (pos_plus2 == len_ext) begin
          crc_high_nxt = in_tdata;
        end
        if (pos_plus1 >= len_ext) begin
          out_status_nxt = ({crc_high_r, in_tdata} == crc_r) ? ST_CRC_GOOD : ST_CRC_BAD;
          out_busy_nxt   = 1'b0;
          phase_nxt      = PH_HUNT;
          position_nxt   = 8'd0;
        end else begin
          position_nxt = pos_plus1[7:0];
        end
      end
      default: begin
        phase_nxt    = PH_HUNT;
        position_nxt = 8'd0;
      end
    endcase

    out_valid_nxt = out_valid_r && !out_tready;
    if (in_fire && emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HUNT;
      position_r     <= 8'd0;
      frame_length_r <= 8'd0;
      crc_r          <= CRC_INIT;
      crc_high_r     <= 8'd0;
      max_frame_r    <= MAX_FRAME_RESET;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_frame_r <= cfg_data;
      end
      if (in_fire) begin
        phase_r        <= phase_nxt;
        position_r     <= position_nxt;
        frame_length_r <= frame_length_nxt;
        crc_r          <= crc_nxt;
        crc_high_r     <= crc_high_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload; load only when a new result is taken in
  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_byte_r   <= out_byte_nxt;
      out_index_r  <= out_index_nxt;
      out_status_r <= out_status_nxt;
      out_busy_r   <= out_busy_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_index_r, out_byte_r};
  assign out_tuser  = {out_busy_r, out_status_r};

`ifndef NO_ASSERTIONS
  // a finished or aborted frame always returns to hunting
  a_end_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && emit && !out_busy_nxt) |=> (phase_r == PH_HUNT))
    else $error("frame end did not return to hunt");

  // inside a frame body the length is valid and the index is below it
  a_body_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> (frame_length_r >= MIN_LEN && position_r < frame_length_r))
    else $error("body position or length out of range");

  // any terminal status reports the frame as no longer busy
  a_status_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_INSIDE) |-> !out_busy_r)
    else $error("terminal status with busy set");

  // a held result must not be overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !in_fire)
    else $error("input taken while result stalled");
`endif

endmodule

// ===== src/sfcd_crc16.sv =====
// ----------------------------------------------------------------------------
// sfcd_crc16
// One-byte update of a CRC-16 (poly 0x1021, MSB first), combinational.
// ----------------------------------------------------------------------------
module sfcd_crc16
  import sfcd_pkg::*;
(
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {data_in, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule
